// ===== hw/rtl/sbs_pkg.sv =====
// Shared types, constants and divide helpers for the spectral band smoother.
// No dependencies; every other file of the block refers to it by scoped names.
package sbs_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int BAND_W    = 9;
   localparam int COUNT_W   = 10;
   localparam int WIN       = 9;
   localparam int LAG       = 4;
   localparam int MAX_BANDS = 512;
   localparam int MIN_BANDS = 9;
   localparam int IDX_W     = 3;
   localparam int ADDR_W    = 5;
   localparam int DATA_W    = 32;

   // Wide sums: nine samples, and three samples with rounding
   localparam int SUM9_W = 20;
   localparam int SUM3_W = 18;

   // Reciprocals: floor(x/9) = (x*DIV9_MUL) >> DIV9_SHIFT for x < 2^21,
   // floor(x/3) = (x*DIV3_MUL) >> DIV3_SHIFT for x < 2^19
   localparam int DIV9_SHIFT = 23;
   localparam logic [SUM9_W-1:0] DIV9_MUL = SUM9_W'(932068);
   localparam int DIV3_SHIFT = 19;
   localparam logic [SUM3_W-1:0] DIV3_MUL = SUM3_W'(174763);

   // Register indexes (byte address / 4)
   typedef enum logic [2:0] {
      REG_BAND_COUNT  = 3'd0,
      REG_SKIP_BAND_A = 3'd1,
      REG_SKIP_BAND_B = 3'd2,
      REG_WIDE_BAND   = 3'd3,
      REG_PAIR_BAND_A = 3'd4,
      REG_PAIR_BAND_B = 3'd5,
      REG_PAIR_BAND_C = 3'd6
   } reg_index_type;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [BAND_W-1:0]   band_type;
   typedef sample_type [WIN-1:0] window_type;

   typedef struct packed {
      logic [COUNT_W-1:0] band_count;
      band_type           skip_band_a;
      band_type           skip_band_b;
      band_type           wide_band;
      band_type           pair_band_a;
      band_type           pair_band_b;
      band_type           pair_band_c;
   } cfg_type;

   // One band waiting to be smoothed, as the work stage presents it
   typedef struct packed {
      logic             valid;
      window_type       win;
      band_type         band;
      logic [IDX_W-1:0] idx;
      logic             is_last;
   } work_type;

   function automatic sample_type div9(input logic [SUM9_W-1:0] x);
      logic [2*SUM9_W-1:0] p;
      p = (2*SUM9_W)'(x) * (2*SUM9_W)'(DIV9_MUL);
      return SAMPLE_W'(p >> DIV9_SHIFT);
   endfunction

   function automatic sample_type div3(input logic [SUM3_W-1:0] x);
      logic [2*SUM3_W-1:0] p;
      p = (2*SUM3_W)'(x) * (2*SUM3_W)'(DIV3_MUL);
      return SAMPLE_W'(p >> DIV3_SHIFT);
   endfunction

endpackage

// ===== hw/rtl/sbs_csr.sv =====
// Configuration registers of the spectral band smoother behind an APB-style port.
// Depends on sbs_pkg for the register indexes and the configuration struct.
module sbs_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [sbs_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [sbs_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [sbs_pkg::DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready,
   output sbs_pkg::cfg_type            cfg
);

   sbs_pkg::cfg_type       cfg_ff;
   sbs_pkg::cfg_type       cfg_in;
   sbs_pkg::reg_index_type reg_sel;
   sbs_pkg::band_type      wdata_band;
   logic                   wr_en;

   assign csr_pready = 1'b1;
   assign reg_sel    = sbs_pkg::reg_index_type'(csr_paddr[sbs_pkg::ADDR_W-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign wdata_band = csr_pwdata[sbs_pkg::BAND_W-1:0];
   assign cfg        = cfg_ff;

   // Decode the write into the selected register
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            sbs_pkg::REG_BAND_COUNT:  cfg_in.band_count  = csr_pwdata[sbs_pkg::COUNT_W-1:0];
            sbs_pkg::REG_SKIP_BAND_A: cfg_in.skip_band_a = wdata_band;
            sbs_pkg::REG_SKIP_BAND_B: cfg_in.skip_band_b = wdata_band;
            sbs_pkg::REG_WIDE_BAND:   cfg_in.wide_band   = wdata_band;
            sbs_pkg::REG_PAIR_BAND_A: cfg_in.pair_band_a = wdata_band;
            sbs_pkg::REG_PAIR_BAND_B: cfg_in.pair_band_b = wdata_band;
            sbs_pkg::REG_PAIR_BAND_C: cfg_in.pair_band_c = wdata_band;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.band_count  <= sbs_pkg::COUNT_W'(9);
         cfg_ff.skip_band_a <= sbs_pkg::BAND_W'(0);
         cfg_ff.skip_band_b <= sbs_pkg::BAND_W'(1);
         cfg_ff.wide_band   <= sbs_pkg::BAND_W'(4);
         cfg_ff.pair_band_a <= sbs_pkg::BAND_W'(5);
         cfg_ff.pair_band_b <= sbs_pkg::BAND_W'(6);
         cfg_ff.pair_band_c <= sbs_pkg::BAND_W'(7);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back the selected register, zero extended
   always_comb begin
      unique case (reg_sel)
         sbs_pkg::REG_BAND_COUNT:  csr_prdata = sbs_pkg::DATA_W'(cfg_ff.band_count);
         sbs_pkg::REG_SKIP_BAND_A: csr_prdata = sbs_pkg::DATA_W'(cfg_ff.skip_band_a);
         sbs_pkg::REG_SKIP_BAND_B: csr_prdata = sbs_pkg::DATA_W'(cfg_ff.skip_band_b);
         sbs_pkg::REG_WIDE_BAND:   csr_prdata = sbs_pkg::DATA_W'(cfg_ff.wide_band);
         sbs_pkg::REG_PAIR_BAND_A: csr_prdata = sbs_pkg::DATA_W'(cfg_ff.pair_band_a);
         sbs_pkg::REG_PAIR_BAND_B: csr_prdata = sbs_pkg::DATA_W'(cfg_ff.pair_band_b);
         sbs_pkg::REG_PAIR_BAND_C: csr_prdata = sbs_pkg::DATA_W'(cfg_ff.pair_band_c);
         default:                  csr_prdata = '0;
      endcase
   end

endmodule

// ===== hw/rtl/sbs_front.sv =====
// Sample window, band counter and work register of the spectral band smoother.
// Depends on sbs_pkg; hands one band at a time to the smoothing logic.
module sbs_front (
   input  logic                 clock,
   input  logic                 reset,
   input  sbs_pkg::cfg_type     cfg,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sbs_pkg::sample_type  req_sample,
   input  logic                 advance,
   output sbs_pkg::work_type    work
);

   sbs_pkg::window_type         win_ff, win_in;
   sbs_pkg::band_type           cnt_ff, cnt_in;
   logic                        wk_valid_ff, wk_valid_in;
   sbs_pkg::window_type         wk_win_ff, wk_win_in;
   sbs_pkg::band_type           wk_band_ff, wk_band_in;
   logic [sbs_pkg::IDX_W-1:0]   wk_idx_ff, wk_idx_in;
   logic                        wk_flush_ff, wk_flush_in;

   logic [sbs_pkg::COUNT_W-1:0] n_eff;
   logic [sbs_pkg::COUNT_W-1:0] c_next;
   logic                        accept;
   logic                        flush;
   logic                        has_result;
   logic                        wk_done;

   // Clamp the configured band count to the supported range
   always_comb begin
      priority if (cfg.band_count < sbs_pkg::COUNT_W'(sbs_pkg::MIN_BANDS)) begin
         n_eff = sbs_pkg::COUNT_W'(sbs_pkg::MIN_BANDS);
      end else if (cfg.band_count > sbs_pkg::COUNT_W'(sbs_pkg::MAX_BANDS)) begin
         n_eff = sbs_pkg::COUNT_W'(sbs_pkg::MAX_BANDS);
      end else begin
         n_eff = cfg.band_count;
      end
   end

   // Work register is done after its last pending band leaves
   assign wk_done    = (wk_idx_ff == '0) | ~wk_flush_ff;
   assign req_ready  = ~wk_valid_ff | (advance & wk_done);
   assign accept     = req_valid & req_ready;
   assign c_next     = sbs_pkg::COUNT_W'(cnt_ff) + 1'b1;
   assign flush      = c_next >= n_eff;
   assign has_result = flush | (cnt_ff >= sbs_pkg::BAND_W'(sbs_pkg::LAG));

   // Shift the window and step the band counter on each accepted item
   always_comb begin
      win_in = win_ff;
      cnt_in = cnt_ff;
      if (accept) begin
         win_in = {win_ff[sbs_pkg::WIN-2:0], req_sample};
         cnt_in = flush ? '0 : c_next[sbs_pkg::BAND_W-1:0];
      end
   end

   // Load the work register with the bands this item releases, then drain it
   always_comb begin
      wk_valid_in = wk_valid_ff;
      wk_win_in   = wk_win_ff;
      wk_band_in  = wk_band_ff;
      wk_idx_in   = wk_idx_ff;
      wk_flush_in = wk_flush_ff;
      if (advance) begin
         wk_idx_in  = wk_idx_ff - 1'b1;
         wk_band_in = wk_band_ff + 1'b1;
         if (wk_done) begin
            wk_valid_in = 1'b0;
         end
      end
      if (accept & has_result) begin
         wk_valid_in = 1'b1;
         wk_win_in   = win_in;
         wk_band_in  = cnt_ff - sbs_pkg::BAND_W'(sbs_pkg::LAG);
         wk_idx_in   = sbs_pkg::IDX_W'(sbs_pkg::LAG);
         wk_flush_in = flush;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff      <= '0;
         cnt_ff      <= '0;
         wk_valid_ff <= 1'b0;
      end else begin
         win_ff      <= win_in;
         cnt_ff      <= cnt_in;
         wk_valid_ff <= wk_valid_in;
      end
   end

   // Payload of the work register
   always_ff @(posedge clock) begin
      wk_win_ff   <= wk_win_in;
      wk_band_ff  <= wk_band_in;
      wk_idx_ff   <= wk_idx_in;
      wk_flush_ff <= wk_flush_in;
   end

   assign work.valid   = wk_valid_ff;
   assign work.win     = wk_win_ff;
   assign work.band    = wk_band_ff;
   assign work.idx     = wk_idx_ff;
   assign work.is_last = wk_flush_ff & (wk_idx_ff == '0);

endmodule

// ===== hw/rtl/sbs_smooth.sv =====
// Per-band smoothing rules of the spectral band smoother.
// Depends on sbs_pkg for the work struct and the divide-by-constant helpers.
module sbs_smooth (
   input  sbs_pkg::cfg_type    cfg,
   input  sbs_pkg::work_type   work,
   output sbs_pkg::sample_type smoothed
);

   sbs_pkg::sample_type              own, up, dn;
   logic [sbs_pkg::SUM9_W-1:0]       sum9;
   logic [sbs_pkg::SUM3_W-1:0]       num3;
   logic [sbs_pkg::SAMPLE_W:0]       pair_sum;
   logic                             is_skip, is_wide, is_pair, is_first;
   sbs_pkg::band_type                b;

   assign b = work.band;

   // Pick the band and its neighbors out of the window
   always_comb begin
      unique case (work.idx)
         3'd0: begin own = work.win[0]; up = work.win[1]; dn = work.win[0]; end
         3'd1: begin own = work.win[1]; up = work.win[2]; dn = work.win[0]; end
         3'd2: begin own = work.win[2]; up = work.win[3]; dn = work.win[1]; end
         3'd3: begin own = work.win[3]; up = work.win[4]; dn = work.win[2]; end
         3'd4: begin own = work.win[4]; up = work.win[5]; dn = work.win[3]; end
         default: begin own = work.win[4]; up = work.win[5]; dn = work.win[3]; end
      endcase
   end

   // Sum the whole window for the wide band
   always_comb begin
      sum9 = sbs_pkg::SUM9_W'(4);
      for (int k = 0; k < sbs_pkg::WIN; k++) begin
         sum9 = sum9 + sbs_pkg::SUM9_W'(work.win[k]);
      end
   end

   assign is_skip  = (b == cfg.skip_band_a) | (b == cfg.skip_band_b);
   assign is_wide  = (b == cfg.wide_band) & (b >= sbs_pkg::BAND_W'(sbs_pkg::LAG))
                     & (work.idx == sbs_pkg::IDX_W'(sbs_pkg::LAG));
   assign is_pair  = (b != '0) & ((b == cfg.pair_band_a) | (b == cfg.pair_band_b)
                     | (b == cfg.pair_band_c));
   assign is_first = (b == '0);
   assign pair_sum = (sbs_pkg::SAMPLE_W+1)'(up) + (sbs_pkg::SAMPLE_W+1)'(own) + 1'b1;

   // Numerator of the three-way divide: first band, last band or plain mean
   always_comb begin
      priority if (is_first) begin
         num3 = {(sbs_pkg::SUM3_W-1)'(own), 1'b0} + sbs_pkg::SUM3_W'(dn) + 1'b1;
      end else if (work.is_last) begin
         num3 = sbs_pkg::SUM3_W'(up) + {(sbs_pkg::SUM3_W-1)'(own), 1'b0} + 1'b1;
      end else begin
         num3 = sbs_pkg::SUM3_W'(up) + sbs_pkg::SUM3_W'(own)
                + sbs_pkg::SUM3_W'(dn) + 1'b1;
      end
   end

   // Apply the rules in order of precedence
   always_comb begin
      priority if (is_skip) begin
         smoothed = own;
      end else if (is_wide) begin
         smoothed = sbs_pkg::div9(sum9);
      end else if (is_pair) begin
         smoothed = pair_sum[sbs_pkg::SAMPLE_W:1];
      end else begin
         smoothed = sbs_pkg::div3(num3);
      end
   end

endmodule

// ===== hw/rtl/spectral_band_smoother.sv =====
// Top level of the spectral band smoother: registers, window, smoothing and result register.
// Depends on sbs_pkg, sbs_csr, sbs_front and sbs_smooth.
//
//   port group | direction | carries
//   req_       | in        | one radiance sample per item, band order, pixel after pixel
//   rsp_       | out       | smoothed sample, its band index and the pixel end mark
//   csr_       | in/out    | APB-style access to the seven configuration registers
//
// An item enters every cycle unless output stalls or a pixel end drains; each from band four
// on releases the band four below it via the work and result registers. A pixel's last band
// releases five, which drain one a cycle unless stalled, through the single smoothing path.
// Reset clears the window, the band counter and all valid flags, and loads default registers.
// A stalled result holds the result register; one more item can sit in the work register.
module spectral_band_smoother (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [15:0]                 req_sample,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [15:0]                 rsp_smoothed,
   output logic [8:0]                  rsp_band_index,
   output logic                        rsp_pixel_end,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [sbs_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [sbs_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [sbs_pkg::DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready
);

   sbs_pkg::cfg_type    cfg;
   sbs_pkg::work_type   work;
   sbs_pkg::sample_type smoothed;
   logic                advance;

   logic                rsp_valid_ff, rsp_valid_in;
   sbs_pkg::sample_type rsp_smoothed_ff;
   sbs_pkg::band_type   rsp_band_ff;
   logic                rsp_end_ff;

   sbs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sbs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .advance    (advance),
      .work       (work)
   );

   sbs_smooth u_smooth (
      .cfg      (cfg),
      .work     (work),
      .smoothed (smoothed)
   );

   // Move a band into the result register when it is empty or being taken
   assign advance      = work.valid & (~rsp_valid_ff | rsp_ready);
   assign rsp_valid_in = advance | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the result payload until the next band arrives
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_smoothed_ff <= smoothed;
         rsp_band_ff     <= work.band;
         rsp_end_ff      <= work.is_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_smoothed   = rsp_smoothed_ff;
   assign rsp_band_index = rsp_band_ff;
   assign rsp_pixel_end  = rsp_end_ff;

endmodule
